// File: hdl/spatial_hash_grid_build_macros.svh
// ----------------------------------------------------------------------------
// spatial hash grid build assertion macros
// shared assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef SPATIAL_HASH_GRID_BUILD_MACROS_SVH
`define SPATIAL_HASH_GRID_BUILD_MACROS_SVH

// clocked assertion, off while reset is held
`define SHGB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds through reset
`define SHGB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/shgb_pkg.sv
// ----------------------------------------------------------------------------
// shgb_pkg
// shared widths, constants and codes of the spatial hash grid build
// ----------------------------------------------------------------------------
`default_nettype none

package shgb_pkg;

  localparam int MAX_PARTICLES = 1024;
  localparam int IDX_W         = $clog2(MAX_PARTICLES);
  localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
  localparam int POS_W         = 24;
  localparam int HASH_W        = 32;

  localparam int DIVD_W        = HASH_W;
  localparam int DIVS_W        = POS_W;
  localparam int DIV_STEP_W    = $clog2(DIVD_W + 1);

  localparam logic [HASH_W-1:0] HASH_MUL_X = 32'd15823;
  localparam logic [HASH_W-1:0] HASH_MUL_Y = 32'd9737333;

  localparam logic [POS_W-1:0]  RADIUS_RST = 24'd256;
  localparam logic [CNT_W-1:0]  COUNT_RST  = CNT_W'(MAX_PARTICLES);

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_BUILD  = 2'd1;
  localparam logic [1:0] CMD_RD_SLOT = 2'd2;
  localparam logic [1:0] CMD_RD_KEY = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic REG_RADIUS = 1'b0;
  localparam logic REG_COUNT  = 1'b1;

endpackage

`default_nettype wire

// File: hdl/shgb_div.sv
// ----------------------------------------------------------------------------
// shgb_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module shgb_div import shgb_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIVD_W-1:0] dividend,
  input  wire logic [DIVS_W-1:0] divisor,
  output logic                   done,
  output logic      [DIVD_W-1:0] quotient,
  output logic      [DIVS_W-1:0] remainder
);

  logic [DIV_STEP_W-1:0] cnt_r;
  logic                  done_r;
  logic [DIVS_W-1:0]     rem_r, rem_nxt;
  logic [DIVD_W-1:0]     quo_r, quo_nxt;
  logic [DIVS_W-1:0]     dvs_r;
  logic [DIVS_W:0]       shifted, diff;
  logic                  ge;

  always_comb begin
    shifted = {rem_r, quo_r[DIVD_W-1]};
    ge      = shifted >= {1'b0, dvs_r};
    diff    = shifted - {1'b0, dvs_r};
    rem_nxt = ge ? diff[DIVS_W-1:0] : shifted[DIVS_W-1:0];
    quo_nxt = {quo_r[DIVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= DIV_STEP_W'(DIVD_W);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_STEP_W'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// File: hdl/spatial_hash_grid_build.sv
// load: two parallel 32-step divides, multiply, 32-step modulo, from accept to result
// reads and out-of-range commands answer from S_RDWAIT and S_RESP; build runs for n particles
//   (clear and prefix sweeps over every key, count and scatter passes over each particle)
// one command at a time: the next is taken in the cycle its result is shown
// after reset busy stays high while the key start table is cleared
// one word at a time; results cannot be stalled, out_valid is high one cycle
// ----------------------------------------------------------------------------
// spatial_hash_grid_build
// hashes particle positions into grid keys and builds a counting-sorted table
// ----------------------------------------------------------------------------
`default_nettype none

module spatial_hash_grid_build import shgb_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [1:0]       in_cmd,
  input  wire logic [POS_W-1:0] in_pos_x,
  input  wire logic [POS_W-1:0] in_pos_y,
  input  wire logic [IDX_W-1:0] in_item_index,
  output logic                  out_valid,
  output logic      [1:0]       out_status,
  output logic      [IDX_W-1:0] out_hash_key,
  output logic      [IDX_W-1:0] out_particle_id,
  output logic      [IDX_W-1:0] out_start_slot,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready
);

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_INIT    = 16'h0002,
    S_RESP    = 16'h0004,
    S_DIV     = 16'h0008,
    S_MUL     = 16'h0010,
    S_ADD     = 16'h0020,
    S_MOD     = 16'h0040,
    S_RDWAIT  = 16'h0080,
    S_CLR     = 16'h0100,
    S_CNT_RD  = 16'h0200,
    S_CNT_KEY = 16'h0400,
    S_CNT_WR  = 16'h0800,
    S_PFX_RD  = 16'h1000,
    S_PFX_WR  = 16'h2000,
    S_SCT_RD  = 16'h4000,
    S_SCT_KEY = 16'h8000
  } state_t;

  localparam logic [CNT_W-1:0] LAST_ENTRY = CNT_W'(MAX_PARTICLES - 1);

  // config registers
  logic [POS_W-1:0] radius_r;
  logic [CNT_W-1:0] count_r;
  logic             cfg_wr;
  logic [POS_W-1:0] r_eff;
  logic [CNT_W-1:0] n_eff;

  // control
  state_t           state_r, state_nxt;
  logic [1:0]       cmd_r, cmd_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] run_r, run_nxt;
  logic [IDX_W-1:0] key_r, key_nxt;
  logic [HASH_W-1:0] px_prod_r, py_prod_r;
  logic             accept, in_range, sct_last;

  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic [IDX_W-1:0] out_key_r, out_key_nxt;
  logic [IDX_W-1:0] out_pid_r, out_pid_nxt;
  logic [IDX_W-1:0] out_slot_r, out_slot_nxt;

  // dividers
  logic              dx_start, dy_start, dx_done, dy_done;
  logic [DIVD_W-1:0] dx_dividend, dx_quo, dy_quo;
  logic [DIVS_W-1:0] dx_divisor, dx_rem, dy_rem;

  // memories
  logic [IDX_W-1:0] lk_mem [MAX_PARTICLES];
  logic [IDX_W-1:0] sk_mem [MAX_PARTICLES];
  logic [IDX_W-1:0] sp_mem [MAX_PARTICLES];
  logic [CNT_W-1:0] ks_mem [MAX_PARTICLES];
  logic [CNT_W-1:0] cnt_mem [MAX_PARTICLES];

  logic             lk_we;
  logic [IDX_W-1:0] lk_waddr, lk_wdata, lk_raddr, lk_rd;
  logic             srt_we;
  logic [IDX_W-1:0] srt_waddr, sk_wdata, sp_wdata, sk_rd, sp_rd;
  logic             ks_we;
  logic [IDX_W-1:0] ks_waddr;
  logic [CNT_W-1:0] ks_wdata, ks_rd;
  logic             cnt_we;
  logic [IDX_W-1:0] cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0] cnt_wdata, cnt_rd;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_COUNT) ? {{(32-CNT_W){1'b0}}, count_r}
                                          : {{(32-POS_W){1'b0}}, radius_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      count_r  <= COUNT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_COUNT) begin
        count_r <= pwdata[CNT_W-1:0];
      end else begin
        radius_r <= pwdata[POS_W-1:0];
      end
    end
  end

  always_comb begin
    r_eff = (radius_r == '0) ? POS_W'(1) : radius_r;
    if (count_r == '0) begin
      n_eff = CNT_W'(1);
    end else if (count_r > CNT_W'(MAX_PARTICLES)) begin
      n_eff = CNT_W'(MAX_PARTICLES);
    end else begin
      n_eff = count_r;
    end
  end

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign in_range = {1'b0, in_item_index} < n_eff;
  assign sct_last = (ptr_r == n_eff - 1'b1);

  // x divider also runs the final modulo
  assign dx_start    = (accept && in_cmd == CMD_LOAD && in_range) || (state_r == S_ADD);
  assign dy_start    = accept && in_cmd == CMD_LOAD && in_range;
  assign dx_dividend = (state_r == S_ADD) ? (px_prod_r + py_prod_r)
                                          : {{(DIVD_W-POS_W){1'b0}}, in_pos_x};
  assign dx_divisor  = (state_r == S_ADD) ? {{(DIVS_W-CNT_W){1'b0}}, n_eff} : r_eff;

  shgb_div u_div_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (dx_start),
    .dividend  (dx_dividend),
    .divisor   (dx_divisor),
    .done      (dx_done),
    .quotient  (dx_quo),
    .remainder (dx_rem)
  );

  shgb_div u_div_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (dy_start),
    .dividend  ({{(DIVD_W-POS_W){1'b0}}, in_pos_y}),
    .divisor   (r_eff),
    .done      (dy_done),
    .quotient  (dy_quo),
    .remainder (dy_rem)
  );

  // hash products, kept to 32 bits
  always_ff @(posedge clk) begin
    if (state_r == S_MUL) begin
      px_prod_r <= {{(HASH_W-POS_W){1'b0}}, dx_quo[POS_W-1:0]} * HASH_MUL_X;
      py_prod_r <= {{(HASH_W-POS_W){1'b0}}, dy_quo[POS_W-1:0]} * HASH_MUL_Y;
    end
  end

  // memory read addresses
  assign lk_raddr  = ptr_r[IDX_W-1:0];
  assign cnt_raddr = (state_r == S_PFX_RD) ? ptr_r[IDX_W-1:0] : lk_rd;

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    ptr_nxt        = ptr_r;
    run_nxt        = run_r;
    key_nxt        = key_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_pid_nxt    = out_pid_r;
    out_slot_nxt   = out_slot_r;
    lk_we          = 1'b0;
    lk_waddr       = idx_r;
    lk_wdata       = dx_rem[IDX_W-1:0];
    srt_we         = 1'b0;
    srt_waddr      = cnt_rd[IDX_W-1:0];
    sk_wdata       = key_r;
    sp_wdata       = ptr_r[IDX_W-1:0];
    ks_we          = 1'b0;
    ks_waddr       = ptr_r[IDX_W-1:0];
    ks_wdata       = '0;
    cnt_we         = 1'b0;
    cnt_waddr      = ptr_r[IDX_W-1:0];
    cnt_wdata      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt = in_cmd;
          idx_nxt = in_item_index;
          if (in_cmd == CMD_BUILD) begin
            ptr_nxt   = '0;
            state_nxt = S_CLR;
          end else if (!in_range) begin
            state_nxt = S_RESP;
          end else if (in_cmd == CMD_LOAD) begin
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_RDWAIT;
          end
        end
      end
      S_INIT: begin
        ks_we   = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == LAST_ENTRY) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_RESP: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_RANGE;
        out_key_nxt    = '0;
        out_pid_nxt    = '0;
        out_slot_nxt   = '0;
        state_nxt      = S_IDLE;
      end
      S_DIV: begin
        if (dx_done && dy_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_ADD;
      end
      S_ADD: begin
        state_nxt = S_MOD;
      end
      S_MOD: begin
        if (dx_done) begin
          lk_we          = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_key_nxt    = dx_rem[IDX_W-1:0];
          out_pid_nxt    = '0;
          out_slot_nxt   = '0;
          state_nxt      = S_IDLE;
        end
      end
      S_RDWAIT: begin
        out_valid_nxt = 1'b1;
        out_pid_nxt   = '0;
        out_key_nxt   = '0;
        out_slot_nxt  = '0;
        if (cmd_r == CMD_RD_SLOT) begin
          out_status_nxt = ST_OK;
          out_key_nxt    = sk_rd;
          out_pid_nxt    = sp_rd;
        end else if (ks_rd[CNT_W-1]) begin
          out_status_nxt = ST_OK;
          out_slot_nxt   = ks_rd[IDX_W-1:0];
        end else begin
          out_status_nxt = ST_EMPTY;
        end
        state_nxt = S_IDLE;
      end
      S_CLR: begin
        cnt_we  = 1'b1;
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == LAST_ENTRY) begin
          ptr_nxt   = '0;
          state_nxt = S_CNT_RD;
        end
      end
      S_CNT_RD: begin
        state_nxt = S_CNT_KEY;
      end
      S_CNT_KEY: begin
        key_nxt   = lk_rd;
        state_nxt = S_CNT_WR;
      end
      S_CNT_WR: begin
        // one entry in flight at a time, so no forwarding on the count
        cnt_we    = 1'b1;
        cnt_waddr = key_r;
        cnt_wdata = cnt_rd + 1'b1;
        ptr_nxt   = ptr_r + 1'b1;
        state_nxt = S_CNT_RD;
        if (sct_last) begin
          ptr_nxt   = '0;
          run_nxt   = '0;
          state_nxt = S_PFX_RD;
        end
      end
      S_PFX_RD: begin
        state_nxt = S_PFX_WR;
      end
      S_PFX_WR: begin
        ks_we     = 1'b1;
        ks_wdata  = {cnt_rd != '0, run_r[IDX_W-1:0]};
        cnt_we    = 1'b1;
        cnt_wdata = run_r;
        run_nxt   = run_r + cnt_rd;
        ptr_nxt   = ptr_r + 1'b1;
        state_nxt = S_PFX_RD;
        if (ptr_r == LAST_ENTRY) begin
          ptr_nxt   = '0;
          state_nxt = S_SCT_RD;
        end
      end
      S_SCT_RD: begin
        state_nxt = S_SCT_KEY;
      end
      S_SCT_KEY: begin
        // first pass takes the key and reads its cursor, second pass places and bumps it
        key_nxt   = lk_rd;
        state_nxt = S_SCT_RD;
        cmd_nxt   = CMD_LOAD;
        if (cmd_r == CMD_LOAD) begin
          srt_we    = 1'b1;
          sk_wdata  = key_r;
          cnt_we    = 1'b1;
          cnt_waddr = key_r;
          cnt_wdata = cnt_rd + 1'b1;
          ptr_nxt   = ptr_r + 1'b1;
          cmd_nxt   = CMD_BUILD;
          key_nxt   = key_r;
          if (sct_last) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            out_key_nxt    = '0;
            out_pid_nxt    = '0;
            out_slot_nxt   = '0;
            state_nxt      = S_IDLE;
          end
        end else begin
          state_nxt = S_SCT_KEY;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
      cmd_r       <= CMD_LOAD;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= out_valid_nxt;
      cmd_r       <= cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    run_r        <= run_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_pid_r    <= out_pid_nxt;
    out_slot_r   <= out_slot_nxt;
  end

  // memories: one write and one registered read port each
  always_ff @(posedge clk) begin
    if (lk_we) begin
      lk_mem[lk_waddr] <= lk_wdata;
    end
    lk_rd <= lk_mem[lk_raddr];
  end

  always_ff @(posedge clk) begin
    if (srt_we) begin
      sk_mem[srt_waddr] <= sk_wdata;
      sp_mem[srt_waddr] <= sp_wdata;
    end
    sk_rd <= sk_mem[in_item_index];
    sp_rd <= sp_mem[in_item_index];
  end

  always_ff @(posedge clk) begin
    if (ks_we) begin
      ks_mem[ks_waddr] <= ks_wdata;
    end
    ks_rd <= ks_mem[in_item_index];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    cnt_rd <= cnt_mem[cnt_raddr];
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_hash_key    = out_key_r;
  assign out_particle_id = out_pid_r;
  assign out_start_slot  = out_slot_r;

endmodule

`default_nettype wire

// File: hdl/shgb_checker.sv
// ----------------------------------------------------------------------------
// shgb_checker
// port-level checks on command and result timing, status codes and error words of the grid build
// ----------------------------------------------------------------------------
`default_nettype none

`include "spatial_hash_grid_build_macros.svh"

module shgb_checker import shgb_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             out_valid,
  input wire logic [1:0]       out_status,
  input wire logic [IDX_W-1:0] out_hash_key,
  input wire logic [IDX_W-1:0] out_particle_id,
  input wire logic [IDX_W-1:0] out_start_slot
);

  logic status_known, err_clean;

  assign status_known = out_status == ST_OK || out_status == ST_RANGE || out_status == ST_EMPTY;
  assign err_clean    = out_hash_key == '0 && out_particle_id == '0 && out_start_slot == '0;

  `SHGB_ASSERT(a_accept_busy, start && !busy |=> busy && !out_valid, "accept not followed by busy")
  `SHGB_ASSERT(a_result_idle, out_valid |-> !busy, "result shown while busy")
  `SHGB_ASSERT(a_status_code, out_valid |-> status_known, "bad status code")
  `SHGB_ASSERT(a_err_zero, out_valid && out_status != ST_OK |-> err_clean, "error word not zero")
  `SHGB_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid && busy, "reset did not clear")

endmodule

bind spatial_hash_grid_build shgb_checker u_shgb_checker (.*);

`default_nettype wire

// File: bench/spatial_hash_grid_build_checker.sv
// ----------------------------------------------------------------------------
// spatial hash grid build checker
// watches the command, result and register ports, keeps its own copy of the
// key, sort and start tables, and compares every result word field by field
// ----------------------------------------------------------------------------
`default_nettype none

module spatial_hash_grid_build_checker import shgb_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic             busy,
  input  wire logic [1:0]       in_cmd,
  input  wire logic [POS_W-1:0] in_pos_x,
  input  wire logic [POS_W-1:0] in_pos_y,
  input  wire logic [IDX_W-1:0] in_item_index,
  input  wire logic             out_valid,
  input  wire logic [1:0]       out_status,
  input  wire logic [IDX_W-1:0] out_hash_key,
  input  wire logic [IDX_W-1:0] out_particle_id,
  input  wire logic [IDX_W-1:0] out_start_slot,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  input  wire logic             pready,
  output int                    fail_count,
  output int                    waiting
);

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] hash_key;
    logic [IDX_W-1:0] particle_id;
    logic [IDX_W-1:0] start_slot;
  } grid_reply_t;

  logic [POS_W-1:0] radius;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] particle_key  [MAX_PARTICLES];
  logic [IDX_W-1:0] slot_key      [MAX_PARTICLES];
  logic [IDX_W-1:0] slot_particle [MAX_PARTICLES];
  logic [IDX_W-1:0] first_slot    [MAX_PARTICLES];
  bit               has_start     [MAX_PARTICLES];
  grid_reply_t      pending_replies[$];

  function automatic int unsigned active_count();
    if (count == 0) return 1;
    if (count > MAX_PARTICLES) return MAX_PARTICLES;
    return count;
  endfunction

  function automatic logic [IDX_W-1:0] cell_hash(logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                                                 int unsigned n);
    logic [31:0] r, cx, cy, h;
    r  = (radius == 0) ? 32'd1 : 32'(radius);
    cx = 32'(px) / r;
    cy = 32'(py) / r;
    h  = cx * HASH_MUL_X + cy * HASH_MUL_Y;
    return IDX_W'(h % n);
  endfunction

  // counting sort, stable because particles are placed in index order
  task automatic sort_grid(int unsigned n);
    int unsigned tally [MAX_PARTICLES];
    int unsigned offset [MAX_PARTICLES];
    int unsigned run;
    for (int k = 0; k < MAX_PARTICLES; k++) begin
      tally[k] = 0;
      has_start[k] = 0;
      first_slot[k] = '0;
    end
    for (int i = 0; i < n; i++) tally[particle_key[i]]++;
    run = 0;
    for (int k = 0; k < MAX_PARTICLES; k++) begin
      offset[k] = run;
      if (tally[k] != 0) begin
        has_start[k] = 1;
        first_slot[k] = IDX_W'(run);
      end
      run += tally[k];
    end
    for (int i = 0; i < n; i++) begin
      slot_key[offset[particle_key[i]]] = particle_key[i];
      slot_particle[offset[particle_key[i]]] = IDX_W'(i);
      offset[particle_key[i]]++;
    end
  endtask

  task automatic predict_reply();
    grid_reply_t r;
    int unsigned n;
    n = active_count();
    r = '0;
    if (in_cmd == CMD_BUILD) begin
      sort_grid(n);
    end else if (in_item_index >= n) begin
      r.status = ST_RANGE;
    end else if (in_cmd == CMD_LOAD) begin
      r.hash_key = cell_hash(in_pos_x, in_pos_y, n);
      particle_key[in_item_index] = r.hash_key;
    end else if (in_cmd == CMD_RD_SLOT) begin
      r.hash_key = slot_key[in_item_index];
      r.particle_id = slot_particle[in_item_index];
    end else if (has_start[in_item_index]) begin
      r.start_slot = first_slot[in_item_index];
    end else begin
      r.status = ST_EMPTY;
    end
    pending_replies.push_back(r);
  endtask

  task automatic report_mismatch(string field, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
    fail_count++;
  endtask

  task automatic compare_reply();
    grid_reply_t w;
    if (pending_replies.size() == 0) begin
      report_mismatch("unexpected word", 1, 0);
    end else begin
      w = pending_replies.pop_front();
      if (out_status !== w.status)
        report_mismatch("status", int'(out_status), int'(w.status));
      if (out_hash_key !== w.hash_key)
        report_mismatch("hash_key", int'(out_hash_key), int'(w.hash_key));
      if (out_particle_id !== w.particle_id)
        report_mismatch("particle_id", int'(out_particle_id), int'(w.particle_id));
      if (out_start_slot !== w.start_slot)
        report_mismatch("start_slot", int'(out_start_slot), int'(w.start_slot));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      fail_count = 0;
      radius = RADIUS_RST;
      count = COUNT_RST;
      for (int k = 0; k < MAX_PARTICLES; k++) has_start[k] = 0;
      pending_replies.delete();
    end else begin
      if (out_valid) compare_reply();
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_COUNT) count = pwdata[CNT_W-1:0];
        else radius = pwdata[POS_W-1:0];
      end
      if (start && !busy) predict_reply();
    end
    waiting = pending_replies.size();
  end

endmodule

`default_nettype wire

// File: bench/spatial_hash_grid_build_test.sv
// ----------------------------------------------------------------------------
// spatial hash grid build test
// loads particle sets, builds the sorted table and reads it back under
// several radius and count settings, with random gaps on the command side
// ----------------------------------------------------------------------------
`default_nettype none

module spatial_hash_grid_build_test;
  import shgb_pkg::*;

  logic             clk = 0;
  logic             rst_n = 0;
  logic             start = 0;
  logic [1:0]       in_cmd = CMD_LOAD;
  logic [POS_W-1:0] in_pos_x = '0;
  logic [POS_W-1:0] in_pos_y = '0;
  logic [IDX_W-1:0] in_item_index = '0;
  logic             psel = 0;
  logic             penable = 0;
  logic             pwrite = 0;
  logic [2:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  wire              busy, out_valid, pready;
  wire  [1:0]       out_status;
  wire  [IDX_W-1:0] out_hash_key, out_particle_id, out_start_slot;
  wire  [31:0]      prdata;
  int               fail_count, waiting;

  int unsigned      grid_size = MAX_PARTICLES;
  int unsigned      words_sent, loads, builds, slot_reads, key_reads;

  always #2 clk = ~clk;

  spatial_hash_grid_build uut (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_pos_x, .in_pos_y, .in_item_index,
    .out_valid, .out_status, .out_hash_key, .out_particle_id, .out_start_slot,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  spatial_hash_grid_build_checker grid_check (
    .clk, .rst_n, .start, .busy, .in_cmd, .in_pos_x, .in_pos_y, .in_item_index,
    .out_valid, .out_status, .out_hash_key, .out_particle_id, .out_start_slot,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready, .fail_count, .waiting
  );

  task automatic issue(logic [1:0] cmd, logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                       logic [IDX_W-1:0] idx);
    int unsigned gap_pct;
    gap_pct = (words_sent < 550) ? 20 : (words_sent < 1100) ? 60 : 0;
    if ($urandom_range(99) < gap_pct) begin
      start <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    start <= 1;
    in_cmd <= cmd;
    in_pos_x <= px;
    in_pos_y <= py;
    in_item_index <= idx;
    do @(posedge clk); while (busy);
    words_sent++;
    case (cmd)
      CMD_LOAD: loads++;
      CMD_BUILD: builds++;
      CMD_RD_SLOT: slot_reads++;
      default: key_reads++;
    endcase
  endtask

  // wait for every outstanding word, then for the block to go idle
  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (waiting != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic addr_sel, logic [31:0] value);
    drain();
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= {addr_sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    if (addr_sel == REG_COUNT) begin
      grid_size = (value[CNT_W-1:0] == 0) ? 1 :
                  (value[CNT_W-1:0] > MAX_PARTICLES) ? MAX_PARTICLES : value[CNT_W-1:0];
    end
  endtask

  function automatic logic [POS_W-1:0] pick_pos(int unsigned style);
    case (style)
      0: return POS_W'($urandom);
      1: return POS_W'($urandom_range(0, 2047));
      default: return $urandom_range(1) ? '1 : '0;
    endcase
  endfunction

  task automatic read_back(int unsigned reads);
    for (int r = 0; r < reads; r++) begin
      case ($urandom_range(5))
        0, 1: issue(CMD_RD_SLOT, '0, '0, IDX_W'($urandom_range(0, grid_size - 1)));
        2, 3: issue(CMD_RD_KEY, '0, '0, IDX_W'($urandom_range(0, grid_size - 1)));
        4: issue(CMD_RD_KEY, POS_W'($urandom), POS_W'($urandom), IDX_W'($urandom));
        default: begin
          if (grid_size < MAX_PARTICLES)
            issue($urandom_range(1) ? CMD_RD_SLOT : CMD_LOAD, POS_W'($urandom),
                  POS_W'($urandom), IDX_W'($urandom_range(grid_size, MAX_PARTICLES - 1)));
        end
      endcase
    end
  endtask

  task automatic grid_round(logic [31:0] count_val, logic [31:0] radius_val, bit stale);
    int unsigned style;
    write_reg(REG_RADIUS, radius_val);
    write_reg(REG_COUNT, count_val);
    style = $urandom_range(2);
    for (int i = 0; i < grid_size; i++)
      issue(CMD_LOAD, pick_pos(style), pick_pos(style), IDX_W'(i));
    // shrink the count so loaded keys can exceed the new modulus
    if (stale && grid_size > 1) write_reg(REG_COUNT, $urandom_range(1, grid_size - 1));
    issue(CMD_BUILD, POS_W'($urandom), POS_W'($urandom), IDX_W'($urandom));
    read_back($urandom_range(8, 20));
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: empty table, range errors, corner positions, zero radius
    write_reg(REG_COUNT, 4);
    issue(CMD_RD_KEY, '0, '0, '0);
    issue(CMD_RD_KEY, '0, '0, 3);
    issue(CMD_RD_SLOT, '0, '0, 5);
    issue(CMD_RD_KEY, '1, '1, '1);
    issue(CMD_LOAD, '1, '1, '1);
    issue(CMD_LOAD, '0, '0, 0);
    issue(CMD_LOAD, '1, '1, 1);
    issue(CMD_LOAD, '1, '0, 2);
    issue(CMD_LOAD, '0, '1, 3);
    issue(CMD_BUILD, '0, '0, '0);
    for (int i = 0; i < 4; i++) issue(CMD_RD_SLOT, '0, '0, IDX_W'(i));
    for (int i = 0; i < 4; i++) issue(CMD_RD_KEY, '0, '0, IDX_W'(i));
    write_reg(REG_RADIUS, 0);
    issue(CMD_LOAD, 24'h000300, 24'h000700, 0);
    write_reg(REG_COUNT, 0);
    issue(CMD_LOAD, '1, '1, 0);
    issue(CMD_BUILD, '0, '0, '0);
    issue(CMD_RD_SLOT, '0, '0, 0);
    issue(CMD_RD_KEY, '0, '0, 0);

    for (int round = 0; round < 15; round++) begin
      logic [31:0] rad, cnt;
      case ($urandom_range(4))
        0: rad = 0;
        1: rad = 1;
        2: rad = 24'hFFFFFF;
        3: rad = $urandom_range(1, 4096);
        default: rad = POS_W'($urandom);
      endcase
      cnt = (round % 7 == 3) ? $urandom_range(1, 3) : $urandom_range(2, 40);
      grid_round(cnt, rad, $urandom_range(3) == 0);
      if (round == 4) begin
        drain();
        read_back(6);
      end
      if (round == 12) grid_round(32'h7FF, $urandom_range(64, 1024), 0);
    end
    drain();
    repeat (20) @(posedge clk);

    $display("covered %0d words: %0d loads, %0d builds, %0d slot reads, %0d key reads",
             words_sent, loads, builds, slot_reads, key_reads);
    $display("radius and count taken through zero, one and full scale, stale keys included");
    if (fail_count == 0 && waiting == 0) begin
      $display("** spatial_hash_grid_build: PASSED **");
    end else begin
      $display("** spatial_hash_grid_build: FAILED **");
    end
    $finish;
  end

  initial begin
    #16000000;
    $display("timeout with %0d words outstanding", waiting);
    $display("** spatial_hash_grid_build: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

// File: spatial_hash_grid_build.f
+incdir+hdl
hdl/shgb_pkg.sv
hdl/shgb_div.sv
hdl/spatial_hash_grid_build.sv
hdl/shgb_checker.sv
bench/spatial_hash_grid_build_checker.sv
bench/spatial_hash_grid_build_test.sv
